[rtl/deq_pkg.sv]
`default_nettype none

package deq_pkg;

  // Default number of entries in the ring
  localparam int unsigned DEPTH_DEF = 1024;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned COUNT_W = 11;

  // Operation codes; any other code is treated as status
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_FRONT = 3'd4;
  localparam logic [OP_W-1:0] OP_READ_BACK  = 3'd5;
  localparam logic [OP_W-1:0] OP_STATUS     = 3'd6;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [DATA_W-1:0] value;
  } deq_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic                     value_valid;
    logic                     error;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;
  } deq_out_t;

endpackage

`default_nettype wire

[rtl/deq_ram.sv]
`default_nettype none

module deq_ram
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  wire logic [DATA_W-1:0]          wr_data,
  input  wire logic                       rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic      [DATA_W-1:0]          rd_data
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // Write one word per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Register read data; it appears in the cycle after rd_en
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[rtl/double_ended_queue_top.sv]
// Double-ended queue over a ring of DEPTH words in one synchronous RAM.
// The result strobe comes in the cycle after the request is taken.
// Throughput: one request per cycle; each request does at most one RAM write
// or one RAM read, and the read data lands in the RAM output register.
// Reset (synchronous, rst_n low) empties the queue; RAM contents are not cleared.
// Results cannot be stalled: out_valid is a one-cycle strobe.
`default_nettype none

module double_ended_queue_top
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire deq_in_t  in_data,
  output logic          out_valid,
  output deq_out_t      out_data
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
  localparam logic [SW-1:0] DEPTH_SUM = SW'(DEPTH);

  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          out_valid_r;
  logic          vv_r, vv_nxt;
  logic          err_r, err_nxt;
  logic [CW-1:0] count_r;

  logic          accept;
  logic          full;
  logic          empty;
  logic [AW-1:0] front_dec;
  logic [AW-1:0] front_inc;
  logic [SW-1:0] tail_sum;
  logic [SW-1:0] back_sum;
  logic [AW-1:0] tail_idx;
  logic [AW-1:0] back_idx;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [DATA_W-1:0] rd_data;

  // Every request is taken as soon as it is presented, so requests are never held off
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign full  = (fill_r == FULL_CNT);
  assign empty = (fill_r == '0);

  // Wrap the front pointer in both directions
  assign front_dec = (front_r == '0) ? LAST_IDX : front_r - 1'b1;
  assign front_inc = (front_r == LAST_IDX) ? '0 : front_r + 1'b1;

  // Locate the free slot past the back and the back element
  assign tail_sum = SW'(front_r) + SW'(fill_r);
  assign back_sum = tail_sum - 1'b1;
  assign tail_idx = (tail_sum >= DEPTH_SUM) ? AW'(tail_sum - DEPTH_SUM) : AW'(tail_sum);
  assign back_idx = (back_sum >= DEPTH_SUM) ? AW'(back_sum - DEPTH_SUM) : AW'(back_sum);

  // Decode the request into at most one RAM access and pointer updates
  always_comb begin
    front_nxt = front_r;
    fill_nxt  = fill_r;
    vv_nxt    = 1'b0;
    err_nxt   = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = tail_idx;
    rd_en     = 1'b0;
    rd_addr   = front_r;
    if (accept) begin
      case (in_data.operation)
        OP_PUSH_FRONT: begin
          if (full) begin
            err_nxt = 1'b1;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = front_dec;
            front_nxt = front_dec;
            fill_nxt  = fill_r + 1'b1;
          end
        end
        OP_PUSH_BACK: begin
          if (full) begin
            err_nxt = 1'b1;
          end else begin
            wr_en    = 1'b1;
            wr_addr  = tail_idx;
            fill_nxt = fill_r + 1'b1;
          end
        end
        OP_POP_FRONT, OP_READ_FRONT: begin
          if (empty) begin
            err_nxt = 1'b1;
          end else begin
            rd_en   = 1'b1;
            rd_addr = front_r;
            vv_nxt  = 1'b1;
            if (in_data.operation == OP_POP_FRONT) begin
              front_nxt = front_inc;
              fill_nxt  = fill_r - 1'b1;
            end
          end
        end
        OP_POP_BACK, OP_READ_BACK: begin
          if (empty) begin
            err_nxt = 1'b1;
          end else begin
            rd_en   = 1'b1;
            rd_addr = back_idx;
            vv_nxt  = 1'b1;
            if (in_data.operation == OP_POP_BACK) begin
              fill_nxt = fill_r - 1'b1;
            end
          end
        end
        OP_STATUS: begin
        end
        default: begin
        end
      endcase
    end
  end

  deq_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data.value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Hold pointers and result flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      front_r     <= front_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= accept;
    end
  end

  // Capture result status alongside the RAM read
  always_ff @(posedge clk) begin
    vv_r    <= vv_nxt;
    err_r   <= err_nxt;
    count_r <= fill_nxt;
  end

  // Drive the result
  assign out_valid             = out_valid_r;
  assign out_data.result_value = vv_r ? $signed(rd_data) : '0;
  assign out_data.value_valid  = vv_r;
  assign out_data.error        = err_r;
  assign out_data.count        = COUNT_W'(count_r);
  assign out_data.is_empty     = (count_r == '0);

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_CNT)
    else $error("fill count exceeds depth");

  a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
    front_r <= LAST_IDX)
    else $error("front pointer out of range");

  a_valid_xor_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.value_valid && out_data.error))
    else $error("result both valid and in error");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("request produced no result");

  a_pop_front: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.operation == OP_POP_FRONT && !empty)
    |=> (fill_r == $past(fill_r) - 1'b1) && (front_r == $past(front_inc)))
    else $error("pop front did not advance state");

endmodule

`default_nettype wire

[dv/deq_result_checker.sv]
`timescale 1ns / 1ps

module deq_result_checker
  import deq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  deq_in_t  in_data,
  input  logic     out_valid,
  input  deq_out_t out_data,
  output int       fail_count,
  output int       pending
);

  localparam int unsigned RING_DEPTH = DEPTH_DEF;
  localparam int unsigned IDX_W      = $clog2(RING_DEPTH);

  // Shadow copy of the ring, its front position and its occupancy
  logic signed [DATA_W-1:0] ring_mem [RING_DEPTH];
  logic [IDX_W-1:0]         head_idx;
  logic [COUNT_W-1:0]       fill_level;
  deq_out_t                 results_due [$];
  int                       mismatches;

  // Count one mismatch and print it
  task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] got,
                               input logic [DATA_W-1:0] want);
    mismatches++;
    $display("%0t deq mismatch: %s got 0x%h expected 0x%h", $time, what, got, want);
  endtask

  // Apply one request to the shadow ring and return the response it gives
  function automatic deq_out_t predict_deq_result(input deq_in_t req);
    deq_out_t    rsp;
    int unsigned pos;
    rsp = '0;
    case (req.operation)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (fill_level >= RING_DEPTH) begin
          rsp.error = 1'b1;
        end else begin
          if (req.operation == OP_PUSH_FRONT) begin
            head_idx = IDX_W'((head_idx + RING_DEPTH - 1) % RING_DEPTH);
            pos      = 32'(head_idx);
          end else begin
            pos = (head_idx + fill_level) % RING_DEPTH;
          end
          ring_mem[pos] = req.value;
          fill_level++;
        end
      end
      OP_POP_FRONT, OP_READ_FRONT: begin
        if (fill_level == 0) begin
          rsp.error = 1'b1;
        end else begin
          rsp.result_value = ring_mem[head_idx];
          rsp.value_valid  = 1'b1;
          if (req.operation == OP_POP_FRONT) begin
            head_idx = IDX_W'((head_idx + 1) % RING_DEPTH);
            fill_level--;
          end
        end
      end
      OP_POP_BACK, OP_READ_BACK: begin
        if (fill_level == 0) begin
          rsp.error = 1'b1;
        end else begin
          pos              = (head_idx + fill_level - 1) % RING_DEPTH;
          rsp.result_value = ring_mem[pos];
          rsp.value_valid  = 1'b1;
          if (req.operation == OP_POP_BACK) begin
            fill_level--;
          end
        end
      end
      // status and the unused code leave everything alone
      default: ;
    endcase
    rsp.count    = fill_level;
    rsp.is_empty = (fill_level == 0);
    return rsp;
  endfunction

  // Queue a prediction per accepted request, then match each strobed response
  always @(posedge clk) begin
    deq_out_t want;
    if (!rst_n) begin
      head_idx   = '0;
      fill_level = '0;
      results_due.delete();
    end else begin
      if (start && !busy) begin
        results_due.insert(results_due.size(), predict_deq_result(in_data));
      end
      if (out_valid) begin
        if (results_due.size() == 0) begin
          flag_mismatch("response with no request outstanding",
                        DATA_W'(out_data.count), '0);
        end else begin
          want = results_due[0];
          results_due.delete(0);
          if (out_data.result_value !== want.result_value)
            flag_mismatch("result_value", out_data.result_value, want.result_value);
          if (out_data.value_valid !== want.value_valid)
            flag_mismatch("value_valid", DATA_W'(out_data.value_valid),
                          DATA_W'(want.value_valid));
          if (out_data.error !== want.error)
            flag_mismatch("error", DATA_W'(out_data.error), DATA_W'(want.error));
          if (out_data.count !== want.count)
            flag_mismatch("count", DATA_W'(out_data.count), DATA_W'(want.count));
          if (out_data.is_empty !== want.is_empty)
            flag_mismatch("is_empty", DATA_W'(out_data.is_empty),
                          DATA_W'(want.is_empty));
        end
      end
    end
    pending    <= results_due.size();
    fail_count <= mismatches;
  end

endmodule

[dv/tb_double_ended_queue_top.sv]
`timescale 1ns / 1ps

module tb_double_ended_queue_top;
  import deq_pkg::*;

  localparam int unsigned RING_DEPTH = DEPTH_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam logic signed [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam int RUN_LIMIT    = 200000;
  localparam int DRAIN_CYCLES = 8;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  deq_in_t  in_data;
  logic     out_valid;
  deq_out_t out_data;

  int fail_count;
  int pending_cnt;
  int cycle_cnt;
  int idle_pct;
  int occupancy;

  double_ended_queue_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  deq_result_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= RUN_LIMIT);
    $display("FAIL");
    $finish;
  end

  // Mostly random words, with the extremes mixed in
  function automatic logic signed [DATA_W-1:0] random_word();
    case ($urandom_range(9))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Idle at random, present one request and hold it until taken
  task automatic send_req(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] val);
    deq_in_t req;
    req.operation = op;
    req.value     = val;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
    // track occupancy only to steer the fill and drain phases
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: if (occupancy < int'(RING_DEPTH)) occupancy++;
      OP_POP_FRONT, OP_POP_BACK:   if (occupancy > 0) occupancy--;
      default: ;
    endcase
  endtask

  // Pick an operation class by the given push and pop percentages
  task automatic send_random(input int push_pct, input int pop_pct);
    int              roll;
    logic [OP_W-1:0] op;
    roll = $urandom_range(99);
    if (roll < push_pct) begin
      op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    end else if (roll < push_pct + pop_pct) begin
      op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
    end else begin
      case ($urandom_range(3))
        0:       op = OP_READ_FRONT;
        1:       op = OP_READ_BACK;
        2:       op = OP_STATUS;
        default: op = OP_UNUSED;
      endcase
    end
    send_req(op, random_word());
  endtask

  // Drop start and hold until every response has come back
  task automatic settle_all();
    start <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
  endtask

  initial begin
    rst_n    <= 1'b0;
    start    <= 1'b0;
    in_data  <= '0;
    idle_pct = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty deque: every pop and read must error, status and unused code must not
    send_req(OP_POP_FRONT,  random_word());
    send_req(OP_POP_BACK,   random_word());
    send_req(OP_READ_FRONT, random_word());
    send_req(OP_READ_BACK,  random_word());
    send_req(OP_STATUS,     random_word());
    send_req(OP_UNUSED,     random_word());
    // Extremes at both ends, then read and unwind them
    send_req(OP_PUSH_BACK,  WORD_MAX);
    send_req(OP_PUSH_FRONT, WORD_MIN);
    send_req(OP_PUSH_BACK,  '0);
    send_req(OP_PUSH_FRONT, '1);
    send_req(OP_READ_FRONT, '0);
    send_req(OP_READ_BACK,  '0);
    send_req(OP_STATUS,     '0);
    send_req(OP_UNUSED,     '1);
    send_req(OP_POP_BACK,   '0);
    send_req(OP_POP_FRONT,  '0);
    send_req(OP_READ_BACK,  '0);
    send_req(OP_POP_FRONT,  '0);
    send_req(OP_POP_BACK,   '0);
    send_req(OP_POP_BACK,   '0);
    // Single element pushed at the front, taken from the back
    send_req(OP_PUSH_FRONT, 32'sd5);
    send_req(OP_READ_BACK,  '0);
    send_req(OP_POP_BACK,   '0);

    // Shallow random traffic around empty, no idling
    repeat (60) send_random(30, 30);

    // Fill to full, then hammer pushes on the full ring
    idle_pct = 49;
    while (occupancy < int'(RING_DEPTH)) send_random(94, 3);
    repeat (12) send_random(60, 0);

    // Let everything drain out before turning around
    settle_all();

    // Pull a stretch back out of the full ring
    idle_pct = 32;
    repeat (80) send_random(3, 94);

    // Mixed traffic that keeps the ring wrapping
    idle_pct = 0;
    repeat (40) send_random(40, 30);

    settle_all();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/double_ended_queue_top.sv
dv/deq_result_checker.sv
dv/tb_double_ended_queue_top.sv
